@@ rtl/core/nps_pkg.sv @@
// Package for the note phrase statistics block: sizes, field widths, store entry type.
// No dependencies.
package nps_pkg;
   localparam int MaxNotes = 64;
   localparam int IdxW = $clog2(MaxNotes);
   localparam int CntW = $clog2(MaxNotes + 1);

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] dur;
      logic [6:0]  pitch;
      logic [6:0]  vel;
   } note_type;

   localparam logic [0:0] ModeLoad  = 1'b0;
   localparam logic [0:0] ModeClose = 1'b1;
endpackage

@@ rtl/core/note_phrase_statistics.sv @@
// Note phrase statistics top level: sorted note store, close walk, summary.
// Depends on nps_pkg.
// Load: store searched from the top entry down, one entry shifted per cycle; a note
// that arrives when the store is full is dropped and flagged. Close: each note is
// walked, and each but the last sent out with its output handshake, then one shared
// 32-step shift-subtract divider run for mean duration, mean velocity and density
// (the density run is skipped when the phrase length is zero).
// One beat at a time; ready is low while a beat is in progress.
// Synchronous active high reset clears count, dropped flag, phrase length, control.
module note_phrase_statistics
   import nps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // lsb up: start_beat[15:0], duration_beat[15:0], pitch[6:0], velocity[6:0]
   input  logic [47:0] req_tdata,
   // mode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // lsb up: has_interval, interval[7:0], lowest_note, highest_note, note_count,
   // mean_duration, mean_velocity, density, class_mask, monophonic, overflow
   output logic [95:0] rsp_tdata,
   // is_last
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [2:0] StIdle = 3'd0, StIns = 3'd1, StRd = 3'd2, StWalk = 3'd3,
                          StOut = 3'd4, StDiv = 3'd5, StLast = 3'd6;

   note_type    mem [MaxNotes];
   note_type    rd_ff, prev_ff, new_ff, new_in;
   logic [2:0]  st_ff, st_in;
   logic [CntW-1:0] cnt_ff, cnt_in, pos_ff, pos_in;
   logic        drop_ff, drop_in;
   logic [15:0] plen_ff, plen_in;
   logic [6:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [21:0] sdur_ff, sdur_in;
   logic [12:0] svel_ff, svel_in;
   logic [11:0] mask_ff, mask_in;
   logic        mono_ff, mono_in, ovf_ff, ovf_in;
   logic [16:0] pend_ff, pend_in;
   logic [1:0]  dsel_ff, dsel_in;
   logic [5:0]  dstep_ff, dstep_in;
   logic [31:0] quo_ff, quo_in, dnum_ff, dnum_in;
   logic [32:0] rem_ff, rem_in;
   logic [15:0] mdur_ff, mdur_in, dens_ff, dens_in;
   logic [14:0] mvel_ff, mvel_in;
   logic [95:0] dat_ff, dat_in;
   logic        last_ff, last_in;
   logic        mw_en;
   logic [IdxW-1:0] mw_adr, mr_adr;
   note_type    mw_dat;
   logic [22:0] key_rd, key_new;
   logic [32:0] dv, rtry;
   logic [14:0] pc_mul;
   logic [3:0]  pc_q;
   logic [3:0]  pc;
   logic [16:0] pend_nt;

   always_ff @(posedge clock) begin
      if (mw_en) mem[mw_adr] <= mw_dat;
      rd_ff <= mem[mr_adr];
   end

   assign key_rd  = {rd_ff.start, rd_ff.pitch};
   assign key_new = {new_ff.start, new_ff.pitch};
   // pitch class: quotient by 12 through a reciprocal multiply, exact for 0..127
   assign pc_mul = 15'(rd_ff.pitch) * 15'd171;
   assign pc_q = pc_mul[14:11];
   assign pc = 4'(rd_ff.pitch - 7'(pc_q) * 7'd12);
   assign pend_nt = {1'b0, rd_ff.start} + {1'b0, rd_ff.dur};
   assign dv = (dsel_ff == 2'd2) ? {17'd0, plen_ff} : {26'd0, cnt_ff};
   assign rtry = {rem_ff[31:0], dnum_ff[31]};

   assign req_tready = (st_ff == StIdle);
   assign rsp_tvalid = (st_ff == StOut) || (st_ff == StLast);
   assign rsp_tdata  = dat_ff;
   assign rsp_tlast  = last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {16'd0, plen_ff};

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; pos_in = pos_ff; drop_in = drop_ff;
      plen_in = plen_ff; new_in = new_ff; lo_in = lo_ff; hi_in = hi_ff;
      sdur_in = sdur_ff; svel_in = svel_ff; mask_in = mask_ff; mono_in = mono_ff;
      ovf_in = ovf_ff; pend_in = pend_ff; dsel_in = dsel_ff; dstep_in = dstep_ff;
      quo_in = quo_ff; rem_in = rem_ff; dnum_in = dnum_ff; mdur_in = mdur_ff;
      mvel_in = mvel_ff; dens_in = dens_ff; dat_in = dat_ff;
      last_in = last_ff;
      mw_en = 1'b0; mw_adr = pos_ff[IdxW-1:0]; mw_dat = new_ff;
      mr_adr = IdxW'(pos_ff - CntW'(1));
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         plen_in = csr_pwdata[15:0];
      case (st_ff)
         StIdle: begin
            if (req_tvalid) begin
               new_in = '{start: req_tdata[15:0], dur: req_tdata[31:16],
                          pitch: req_tdata[38:32], vel: req_tdata[45:39]};
               if (req_tuser == ModeClose) begin
                  ovf_in = drop_ff; drop_in = 1'b0;
                  lo_in = 7'd127; hi_in = 7'd0; sdur_in = '0; svel_in = '0;
                  mask_in = '0; mono_in = 1'b1; pos_in = '0;
                  mr_adr = '0;
                  st_in = (cnt_ff == '0) ? StLast : StRd;
                  dat_in = '0; dat_in[90] = drop_ff; last_in = 1'b1;
               end else if (cnt_ff == CntW'(MaxNotes)) begin
                  drop_in = 1'b1;
               end else begin
                  pos_in = cnt_ff;
                  mr_adr = IdxW'(cnt_ff - CntW'(1));
                  st_in = StIns;
               end
            end
         end
         StIns: begin
            // rd_ff holds entry pos-1
            mw_en = 1'b1;
            if (pos_ff != '0 && key_rd > key_new) begin
               mw_dat = rd_ff;
               pos_in = pos_ff - CntW'(1);
               mr_adr = IdxW'(pos_ff - CntW'(2));
            end else begin
               cnt_in = cnt_ff + CntW'(1);
               st_in = StIdle;
            end
         end
         StRd: begin
            mr_adr = pos_ff[IdxW-1:0];
            st_in = StWalk;
         end
         StWalk: begin
            // rd_ff holds entry pos
            if (rd_ff.pitch < lo_ff) lo_in = rd_ff.pitch;
            if (rd_ff.pitch > hi_ff) hi_in = rd_ff.pitch;
            sdur_in = sdur_ff + 22'(rd_ff.dur);
            svel_in = svel_ff + 13'(rd_ff.vel);
            mask_in = mask_ff | (12'd1 << pc);
            pend_in = pend_nt;
            dat_in = '0;
            if (pos_ff != '0) begin
               dat_in[0] = 1'b1;
               dat_in[8:1] = 8'({1'b0, rd_ff.pitch} - {1'b0, prev_ff.pitch});
               if ({1'b0, rd_ff.start} < pend_ff) mono_in = 1'b0;
            end
            last_in = 1'b0;
            if (pos_ff == cnt_ff - CntW'(1)) begin
               st_in = StDiv; dsel_in = 2'd0; dstep_in = '0;
               dnum_in = {10'd0, sdur_in}; rem_in = '0; quo_in = '0;
            end else st_in = StOut;
         end
         StOut: begin
            if (rsp_tready) begin
               pos_in = pos_ff + CntW'(1);
               mr_adr = pos_in[IdxW-1:0];
               st_in = StWalk;
            end
         end
         StDiv: begin
            if (dstep_ff != 6'd32 && dsel_ff != 2'd3) begin
               if (rtry >= dv) begin
                  rem_in = rtry - dv; quo_in = {quo_ff[30:0], 1'b1};
               end else begin
                  rem_in = rtry; quo_in = {quo_ff[30:0], 1'b0};
               end
               dnum_in = {dnum_ff[30:0], 1'b0};
               dstep_in = dstep_ff + 6'd1;
            end else begin
               dstep_in = '0; rem_in = '0; quo_in = '0;
               case (dsel_ff)
                  2'd0: begin
                     mdur_in = quo_ff[15:0];
                     dsel_in = 2'd1; dnum_in = {11'd0, svel_ff, 8'd0};
                  end
                  2'd1: begin
                     mvel_in = quo_ff[14:0];
                     dsel_in = 2'd2; dnum_in = {9'd0, cnt_ff, 16'd0};
                     if (plen_ff == '0) begin
                        dens_in = '0; dsel_in = 2'd3;
                     end
                  end
                  2'd2: begin
                     dens_in = (quo_ff > 32'hFFFF) ? 16'hFFFF : quo_ff[15:0];
                     dsel_in = 2'd3;
                  end
                  default: begin
                     dat_in[15:9]  = lo_ff;
                     dat_in[22:16] = hi_ff;
                     dat_in[29:23] = 7'(cnt_ff);
                     dat_in[45:30] = mdur_ff;
                     dat_in[60:46] = mvel_ff;
                     dat_in[76:61] = dens_ff;
                     dat_in[88:77] = mask_ff;
                     dat_in[89] = mono_ff;
                     dat_in[90] = ovf_ff;
                     dat_in[95:91] = '0;
                     last_in = 1'b1;
                     st_in = StLast;
                  end
               endcase
            end
         end
         StLast: begin
            if (rsp_tready) begin
               cnt_in = '0;
               st_in = StIdle;
            end
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle; cnt_ff <= '0; drop_ff <= 1'b0; plen_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; drop_ff <= drop_in; plen_ff <= plen_in;
      end
      if (st_ff == StWalk) prev_ff <= rd_ff;
      pos_ff <= pos_in; new_ff <= new_in; lo_ff <= lo_in; hi_ff <= hi_in;
      sdur_ff <= sdur_in; svel_ff <= svel_in; mask_ff <= mask_in; mono_ff <= mono_in;
      ovf_ff <= ovf_in; pend_ff <= pend_in; dsel_ff <= dsel_in; dstep_ff <= dstep_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dnum_ff <= dnum_in; mdur_ff <= mdur_in;
      mvel_ff <= mvel_in; dens_ff <= dens_in; dat_ff <= dat_in;
      last_ff <= last_in;
   end
endmodule
